>>> rtl/arwh_pkg.sv
// arwh_pkg: shared types and constants for the amplifier relay sequencer
// item and result structs, op, mode and register codes, timing limits
// no dependencies
package arwh_pkg;

    localparam int WARMUP_W = 14;
    localparam int HOLD_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [WARMUP_W-1:0] WARMUP_LIMIT = WARMUP_W'(10000);
    localparam logic [HOLD_W-1:0]   HOLD_LIMIT   = HOLD_W'(600000);
    localparam logic [WARMUP_W-1:0] WARMUP_RESET = WARMUP_W'(500);
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(30000);
    localparam logic [WARMUP_W-1:0] WARMUP_SAT   = '1;
    localparam logic [HOLD_W-1:0]   IDLE_SAT     = '1;

    // op codes of an input item
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PLAY = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    // relay modes
    localparam logic [1:0] MODE_AUTO = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = CFG_IDX_W'(3);

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] track;
        logic [7:0] volume;
        logic [7:0] loop_flag;
        logic       player_busy;
    } in_item_t;

    typedef struct packed {
        logic       relay_active;
        logic       pin_level;
        logic       start_strobe;
        logic [7:0] start_track;
        logic [7:0] start_volume;
        logic [7:0] start_loop;
        logic       stop_strobe;
        logic       waiting;
    } out_item_t;

    typedef struct packed {
        logic [1:0]          relay_mode;
        logic [WARMUP_W-1:0] warmup_ms;
        logic [HOLD_W-1:0]   hold_ms;
        logic                active_low;
    } cfg_t;

endpackage

>>> rtl/arwh_cfg.sv
// arwh_cfg: configuration register file with range checks on the timings
// depends on arwh_pkg
module arwh_cfg
    import arwh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_MODE:       cfg_next.relay_mode = wr_data[1:0];
                // out of range timings are dropped
                CFG_WARMUP: begin
                    if (wr_data[WARMUP_W-1:0] <= WARMUP_LIMIT)
                        cfg_next.warmup_ms = wr_data[WARMUP_W-1:0];
                end
                CFG_HOLD: begin
                    if (wr_data[HOLD_W-1:0] <= HOLD_LIMIT)
                        cfg_next.hold_ms = wr_data[HOLD_W-1:0];
                end
                CFG_ACTIVE_LOW: cfg_next.active_low = wr_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.relay_mode <= MODE_AUTO;
            cfg_reg.warmup_ms  <= WARMUP_RESET;
            cfg_reg.hold_ms    <= HOLD_RESET;
            cfg_reg.active_low <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/arwh_seq.sv
// arwh_seq: relay sequencing state and the per-item update logic
// depends on arwh_pkg
module arwh_seq
    import arwh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t res
);

    logic                relay_reg, relay_next;
    logic                pend_reg, pend_next;
    logic [WARMUP_W-1:0] warm_reg, warm_next;
    logic [HOLD_W-1:0]   idle_reg, idle_next;
    logic [7:0]          trk_reg, trk_next;
    logic [7:0]          vol_reg, vol_next;
    logic [7:0]          lp_reg, lp_next;

    logic autom;
    assign autom = (cfg.relay_mode == MODE_AUTO);

    always_comb begin
        relay_next = relay_reg;
        pend_next  = pend_reg;
        warm_next  = warm_reg;
        idle_next  = idle_reg;
        trk_next   = trk_reg;
        vol_next   = vol_reg;
        lp_next    = lp_reg;
        res        = '0;
        case (item.op)
            OP_TICK: begin
                if (idle_reg != IDLE_SAT)
                    idle_next = idle_reg + HOLD_W'(1);
                if (pend_reg) begin
                    if (warm_reg != WARMUP_SAT)
                        warm_next = warm_reg + WARMUP_W'(1);
                    if (warm_next >= cfg.warmup_ms) begin
                        pend_next        = 1'b0;
                        res.start_strobe = 1'b1;
                        res.start_track  = trk_reg;
                        res.start_volume = vol_reg;
                        res.start_loop   = lp_reg;
                        idle_next        = '0;
                    end
                end
                if (cfg.relay_mode == MODE_ON) begin
                    relay_next = 1'b1;
                end else if (!autom) begin
                    relay_next = 1'b0;
                end else if (pend_next || item.player_busy) begin
                    idle_next  = '0;
                    relay_next = 1'b1;
                end else if (relay_reg && idle_next >= cfg.hold_ms) begin
                    relay_next = 1'b0;
                end
            end
            OP_PLAY: begin
                idle_next = '0;
                if (!autom || (relay_reg && !pend_reg) || cfg.warmup_ms == '0) begin
                    if (autom)
                        relay_next = 1'b1;
                    res.start_strobe = 1'b1;
                    res.start_track  = item.track;
                    res.start_volume = item.volume;
                    res.start_loop   = item.loop_flag;
                end else begin
                    // a repeat request keeps the running deadline
                    if (!pend_reg) begin
                        relay_next = 1'b1;
                        warm_next  = '0;
                    end
                    pend_next = 1'b1;
                    trk_next  = item.track;
                    vol_next  = item.volume;
                    lp_next   = item.loop_flag;
                end
            end
            OP_STOP: begin
                pend_next       = 1'b0;
                res.stop_strobe = 1'b1;
                idle_next       = '0;
            end
            default: ;
        endcase
        res.relay_active = relay_next;
        res.pin_level    = relay_next ^ cfg.active_low;
        res.waiting      = pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_reg <= 1'b0;
            pend_reg  <= 1'b0;
            warm_reg  <= '0;
            idle_reg  <= '0;
        end else if (fire) begin
            relay_reg <= relay_next;
            pend_reg  <= pend_next;
            warm_reg  <= warm_next;
            idle_reg  <= idle_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            trk_reg <= trk_next;
            vol_reg <= vol_next;
            lp_reg  <= lp_next;
        end
    end

    a_strobes_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.stop_strobe |-> !res.start_strobe && !res.waiting)
        else $error("stop transfer also starts or keeps a start pending");

    a_idle_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> idle_reg == '0 || idle_reg == $past(idle_reg)
                 || idle_reg == $past(idle_reg) + HOLD_W'(1))
        else $error("idle counter jumped");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !fire |=> $stable(relay_reg) && $stable(pend_reg) && $stable(idle_reg))
        else $error("sequencer state changed without a transfer");

    a_start_clears_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.op == OP_TICK && res.start_strobe |-> !res.waiting)
        else $error("warm-up start left the start pending");

endmodule

>>> rtl/amp_relay_warmup_hold_controller.sv
// amp_relay_warmup_hold_controller: top level of the amplifier relay sequencer
// depends on arwh_pkg, arwh_cfg, arwh_seq
//
//   channel  direction  ports                           payload
//   s_       in         s_valid s_ready s_data          in_item_t
//   m_       out        m_valid m_ready m_data          out_item_t
//   cfg_     in         cfg_valid cfg_ready cfg_index   cfg_data (register write)
//
// every item passes through the input register and then the result register,
// so one transfer per cycle is sustained while m_ready stays high
// the update logic sits between the two registers
// a stalled result register holds its item; an empty input register can take one
// reset (aresetn low, synchronous) empties both registers and restores the defaults
// cfg_ready is always high; writes take effect on the next cycle
module amp_relay_warmup_hold_controller
    import arwh_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t res;
    cfg_t      cfg;
    logic      adv;

    // item moves on when the result register is free or being emptied
    assign adv       = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;

    arwh_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    arwh_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (adv),
        .item    (in_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready)
                in_valid_reg <= s_valid;
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid)
            in_reg <= s_data;
        if (adv)
            out_reg <= res;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule
